/* rtl/idw_pkg.sv */
// Package: shared constants and types for the inverse distance weight engine.
package idw_pkg;

    localparam int MAX_POINTS = 64;
    localparam int IDX_W      = $clog2(MAX_POINTS);
    localparam int CNT_W      = $clog2(MAX_POINTS + 1);
    localparam int COORD_W    = 20;
    localparam int DIFF_W     = COORD_W + 1;
    localparam int SQ_W       = 2 * COORD_W;
    localparam int DIST_W     = SQ_W + 1;
    localparam int WEIGHT_W   = 48;
    localparam int NUM_W      = 41;
    localparam int DEN_W      = 42;
    localparam int QUO_W      = 41;
    localparam int QCNT_W     = 6;

    localparam logic [WEIGHT_W-1:0] WEIGHT_MAX = {WEIGHT_W{1'b1}};
    localparam logic [WEIGHT_W-1:0] ONE_FIXED  = WEIGHT_W'(64'h100_0000);

    typedef enum logic [1:0] {
        OP_LOAD  = 2'd0,
        OP_CLEAR = 2'd1,
        OP_QUERY = 2'd2,
        OP_NONE  = 2'd3
    } op_t;

    typedef enum logic [2:0] {
        ST_OK      = 3'd0,
        ST_SAT     = 3'd1,
        ST_LOADED  = 3'd2,
        ST_FULL    = 3'd3,
        ST_CLEARED = 3'd4
    } status_t;

    typedef enum logic [2:0] {
        S_IDLE, S_SCAN, S_SQR, S_DIV, S_OUT
    } state_t;

    // divider request from the control unit
    typedef struct packed {
        logic             start;
        logic [NUM_W-1:0] num;
        logic [DEN_W-1:0] den;
    } div_req_t;

    typedef struct packed {
        logic             done;
        logic [QUO_W-1:0] quo;
    } div_rsp_t;

endpackage

/* rtl/idw_divider.sv */
// Restoring divider: one quotient bit per cycle.
module idw_divider (
    input  logic              aclk,
    input  logic              aresetn,
    input  idw_pkg::div_req_t req,
    output idw_pkg::div_rsp_t rsp
);
    import idw_pkg::*;

    logic [NUM_W-1:0]  num_reg;
    logic [DEN_W-1:0]  den_reg;
    logic [DEN_W:0]    rem_reg;
    logic [QCNT_W-1:0] cnt_reg;
    logic              busy_reg;
    logic              done_reg;
    logic [DEN_W:0]    shifted;
    logic [DEN_W:0]    diff;

    assign shifted = {rem_reg[DEN_W-1:0], num_reg[NUM_W-1]};
    assign diff    = shifted - {1'b0, den_reg};

    // control
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (req.start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= QCNT_W'(NUM_W - 1);
            end else if (busy_reg) begin
                if (cnt_reg == '0) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
                cnt_reg <= cnt_reg - 1'b1;
            end
        end
    end

    // datapath: quotient shifts into num_reg
    always_ff @(posedge aclk) begin
        if (req.start) begin
            num_reg <= req.num;
            den_reg <= req.den;
            rem_reg <= '0;
        end else if (busy_reg) begin
            if (!diff[DEN_W]) begin
                rem_reg <= diff;
                num_reg <= {num_reg[NUM_W-2:0], 1'b1};
            end else begin
                rem_reg <= shifted;
                num_reg <= {num_reg[NUM_W-2:0], 1'b0};
            end
        end
    end

    assign rsp.done = done_reg;
    assign rsp.quo  = num_reg;

endmodule

/* rtl/inverse_distance_weight_engine.sv */
// Top level: control point table, nearest point scan and weight division.
// Load, clear, unused operations and an empty-table query set the output word on acceptance;
// a query of a non-empty table scans the table, passes setup state S_SQR, runs the bit-serial
// divide. Zero distance, or with alpha 2 or 3 a minimum squared distance D >= 2^21, skips the
// divide. One item in flight: next word once the output is taken and the engine is idle.
// Reset (aresetn low, sync) empties the table, sets alpha to 1.
module inverse_distance_weight_engine (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [47:0] s_tdata,   // operation[1:0], pos_x[21:2], pos_y[41:22]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [55:0] m_tdata,   // weight[47:0], status[50:48]
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_data   // alpha
);
    import idw_pkg::*;

    logic [COORD_W-1:0] mem_x [MAX_POINTS];
    logic [COORD_W-1:0] mem_y [MAX_POINTS];
    logic [COORD_W-1:0] rd_x_reg, rd_y_reg;

    state_t state_reg, state_next;
    logic [1:0]          alpha_reg;
    logic [CNT_W-1:0]    count_reg;
    logic [CNT_W-1:0]    idx_reg;
    logic                rd_vld_reg;
    logic [COORD_W-1:0]  qx_reg, qy_reg;
    logic [DIST_W-1:0]   dmin_reg;
    logic                out_vld_reg;
    logic [WEIGHT_W-1:0] out_w_reg;
    status_t             out_st_reg;

    logic [1:0]          in_op;
    logic [COORD_W-1:0]  in_x, in_y;
    logic                in_acc;
    div_req_t            dreq;
    div_rsp_t            drsp;

    assign in_op  = s_tdata[1:0];
    assign in_x   = s_tdata[21:2];
    assign in_y   = s_tdata[41:22];
    assign s_tready = (state_reg == S_IDLE) && !out_vld_reg;
    assign in_acc = s_tvalid && s_tready;
    assign cfg_ready = 1'b1;

    // distance of the read entry to the query point; |diff| stays below 2^20
    logic signed [DIFF_W-1:0] dx, dy;
    logic [DIFF_W-1:0]        ax, ay;
    logic [DIST_W-1:0]        dist_sq;
    always_comb begin
        dx = DIFF_W'($signed(qx_reg)) - DIFF_W'($signed(rd_x_reg));
        dy = DIFF_W'($signed(qy_reg)) - DIFF_W'($signed(rd_y_reg));
        ax = dx[DIFF_W-1] ? DIFF_W'(-dx) : DIFF_W'(dx);
        ay = dy[DIFF_W-1] ? DIFF_W'(-dy) : DIFF_W'(dy);
        dist_sq = DIST_W'(ax[DIFF_W-2:0] * ax[DIFF_W-2:0])
                + DIST_W'(ay[DIFF_W-2:0] * ay[DIFF_W-2:0]);
    end

    // table memory: one write, one registered read
    always_ff @(posedge aclk) begin
        if (in_acc && in_op == OP_LOAD && count_reg < CNT_W'(MAX_POINTS)) begin
            mem_x[count_reg[IDX_W-1:0]] <= in_x;
            mem_y[count_reg[IDX_W-1:0]] <= in_y;
        end
        rd_x_reg <= mem_x[idx_reg[IDX_W-1:0]];
        rd_y_reg <= mem_y[idx_reg[IDX_W-1:0]];
    end

    logic alpha2;
    assign alpha2 = alpha_reg[1];

    // state register
    always_ff @(posedge aclk) begin
        if (!aresetn) state_reg <= S_IDLE;
        else          state_reg <= state_next;
    end

    // next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE: if (in_acc && in_op == OP_QUERY && count_reg != '0) state_next = S_SCAN;
            S_SCAN: if (rd_vld_reg && idx_reg == count_reg) state_next = S_SQR;
            S_SQR:  state_next = (dmin_reg == '0 ||
                                  (alpha2 && dmin_reg >= DIST_W'(1 << 21))) ? S_OUT : S_DIV;
            S_DIV:  if (drsp.done) state_next = S_OUT;
            S_OUT:  if (!out_vld_reg) state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    // divider request: 2^32/D or 2^40/D^2
    always_comb begin
        dreq.start = (state_reg == S_SQR) && (state_next == S_DIV);
        dreq.num   = alpha2 ? NUM_W'(64'h100_0000_0000) : NUM_W'(64'h1_0000_0000);
        dreq.den   = alpha2 ? DEN_W'(dmin_reg[20:0] * dmin_reg[20:0]) : DEN_W'(dmin_reg);
    end

    idw_divider u_div (.aclk(aclk), .aresetn(aresetn), .req(dreq), .rsp(drsp));

    // control and datapath
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            alpha_reg   <= 2'd1;
            count_reg   <= '0;
            idx_reg     <= '0;
            rd_vld_reg  <= 1'b0;
            out_vld_reg <= 1'b0;
        end else begin
            if (cfg_valid) alpha_reg <= cfg_data;
            if (out_vld_reg && m_tready) out_vld_reg <= 1'b0;
            rd_vld_reg <= 1'b0;
            if (in_acc) begin
                qx_reg   <= in_x;
                qy_reg   <= in_y;
                idx_reg  <= '0;
                dmin_reg <= '1;
                case (in_op)
                    OP_LOAD: begin
                        out_vld_reg <= 1'b1;
                        out_w_reg   <= '0;
                        if (count_reg < CNT_W'(MAX_POINTS)) begin
                            count_reg  <= count_reg + 1'b1;
                            out_st_reg <= ST_LOADED;
                        end else begin
                            out_st_reg <= ST_FULL;
                        end
                    end
                    OP_CLEAR: begin
                        count_reg   <= '0;
                        out_vld_reg <= 1'b1;
                        out_w_reg   <= '0;
                        out_st_reg  <= ST_CLEARED;
                    end
                    OP_QUERY: begin
                        out_st_reg <= ST_OK;
                        out_w_reg  <= (count_reg == '0) ? ONE_FIXED : '0;
                        if (count_reg == '0) out_vld_reg <= 1'b1;
                    end
                    default: begin
                        out_vld_reg <= 1'b1;
                        out_w_reg   <= '0;
                        out_st_reg  <= ST_OK;
                    end
                endcase
            end
            // walk the table, one read per cycle
            if (state_reg == S_SCAN) begin
                if (idx_reg != count_reg) begin
                    idx_reg    <= idx_reg + 1'b1;
                    rd_vld_reg <= 1'b1;
                end
                if (rd_vld_reg && dist_sq < dmin_reg) dmin_reg <= dist_sq;
            end
            if (state_reg == S_SQR && state_next == S_OUT) begin
                out_vld_reg <= 1'b1;
                if (dmin_reg == '0) begin
                    out_w_reg  <= WEIGHT_MAX;
                    out_st_reg <= ST_SAT;
                end else begin
                    out_w_reg <= '0;
                end
            end
            // quotient never exceeds 2^40, so no clamp is needed
            if (state_reg == S_DIV && drsp.done) begin
                out_vld_reg <= 1'b1;
                out_w_reg   <= WEIGHT_W'(drsp.quo);
            end
        end
    end

    assign m_tvalid = out_vld_reg;
    assign m_tdata  = {5'd0, out_st_reg, out_w_reg};

    // a result never appears while scanning
    a_no_out_scan: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_SCAN) |-> !out_vld_reg) else $error("output during scan");
    // table count never exceeds the depth
    a_count_max: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CNT_W'(MAX_POINTS)) else $error("count overflow");
    // divider completes only while dividing
    a_div_done: assert property (@(posedge aclk) disable iff (!aresetn)
        drsp.done |-> (state_reg == S_DIV)) else $error("stray divider done");

endmodule

/* dv/tb_inverse_distance_weight_engine.sv */
// Testbench: inverse distance weight engine, directed and random tests with a scoreboard.
module tb_inverse_distance_weight_engine;
    timeunit 1ns;
    timeprecision 1ps;
    import idw_pkg::*;

    typedef struct {
        logic [47:0] weight;
        status_t     status;
    } weight_word_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [47:0] s_tdata = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [55:0] m_tdata;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [1:0]  cfg_data = '0;

    // predictor state
    logic signed [19:0] pt_x [MAX_POINTS];
    logic signed [19:0] pt_y [MAX_POINTS];
    int unsigned        pt_count = 0;
    logic [1:0]         alpha_reg = 2'd1;

    weight_word_t expected_words [$];
    int unsigned  mismatch_count = 0;
    int unsigned  words_checked = 0;
    int unsigned  items_sent = 0;
    int unsigned  queries_sent = 0;
    longint unsigned cycle_count = 0;
    bit           rx_stall_on = 1'b1;

    inverse_distance_weight_engine i_dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // timeout watchdog
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > 3_000_000) begin
            $display("inverse_distance_weight_engine regression: fail");
            $finish;
        end
    end

    function automatic logic [63:0] abs_sq(logic signed [19:0] a, logic signed [19:0] b);
        longint d;
        d = longint'(a) - longint'(b);
        if (d < 0) d = -d;
        return d * d;
    endfunction

    // compute the expected word and update the table
    function automatic weight_word_t predict_weight(op_t op, logic signed [19:0] px,
                                                    logic signed [19:0] py);
        weight_word_t w;
        logic [63:0] dmin, d, num, den, q;
        w.weight = '0;
        w.status = ST_OK;
        case (op)
            OP_LOAD: begin
                if (pt_count < MAX_POINTS) begin
                    pt_x[pt_count] = px;
                    pt_y[pt_count] = py;
                    pt_count++;
                    w.status = ST_LOADED;
                end else begin
                    w.status = ST_FULL;
                end
            end
            OP_CLEAR: begin
                pt_count = 0;
                w.status = ST_CLEARED;
            end
            OP_QUERY: begin
                if (pt_count == 0) begin
                    w.weight = ONE_FIXED;
                end else begin
                    dmin = '1;
                    for (int i = 0; i < pt_count; i++) begin
                        d = abs_sq(px, pt_x[i]) + abs_sq(py, pt_y[i]);
                        if (d < dmin) dmin = d;
                    end
                    if (dmin == 0) begin
                        w.weight = WEIGHT_MAX;
                        w.status = ST_SAT;
                    end else begin
                        if (alpha_reg <= 2'd1) begin
                            num = 64'd1 << 32;
                            den = dmin;
                        end else begin
                            num = 64'd1 << 40;
                            den = (dmin >= (64'd1 << 21)) ? 64'd0 : dmin * dmin;
                        end
                        q = (den == 0) ? 64'd0 : num / den;
                        if (q > 64'(WEIGHT_MAX)) begin
                            w.weight = WEIGHT_MAX;
                            w.status = ST_SAT;
                        end else begin
                            w.weight = q[47:0];
                        end
                    end
                end
            end
            default: ;
        endcase
        return w;
    endfunction

    function automatic int unsigned gap_len();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 40) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(10, 60);
    endfunction

    // send one word; the prediction is queued at acceptance
    task automatic send_item(op_t op, logic signed [19:0] px, logic signed [19:0] py);
        weight_word_t w;
        s_tvalid <= 1'b1;
        s_tdata  <= {6'd0, py, px, op};
        do @(posedge aclk); while (!s_tready);
        w = predict_weight(op, px, py);
        expected_words.push_back(w);
        items_sent++;
        if (op == OP_QUERY) queries_sent++;
        s_tvalid <= 1'b0;
        // the block is busy after each accepted word anyway
        repeat (gap_len() + 1) @(posedge aclk);
    endtask

    task automatic wait_drained();
        while (expected_words.size() != 0) @(posedge aclk);
        repeat (140) @(posedge aclk);
    endtask

    task automatic write_alpha(logic [1:0] a);
        wait_drained();
        cfg_valid <= 1'b1;
        cfg_data  <= a;
        do @(posedge aclk); while (!cfg_ready);
        alpha_reg = a;
        cfg_valid <= 1'b0;
    endtask

    // receiver stalls
    always @(posedge aclk) begin
        if (!rx_stall_on) m_tready <= 1'b1;
        else m_tready <= ($urandom_range(0, 9) < 7);
    end

    // compare each output word with the oldest expectation
    always @(posedge aclk) begin
        weight_word_t w;
        if (aresetn && m_tvalid && m_tready) begin
            if (expected_words.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= 10)
                    $display("unexpected output word %h", m_tdata);
            end else begin
                w = expected_words.pop_front();
                words_checked++;
                if (m_tdata[47:0] !== w.weight || m_tdata[50:48] !== w.status) begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("mismatch: weight exp %h got %h, status exp %0d got %0d",
                                 w.weight, m_tdata[47:0], w.status, m_tdata[50:48]);
                end
            end
        end
    end

    function automatic logic signed [19:0] rand_coord();
        case ($urandom_range(0, 5))
            0: return 20'sh80000;
            1: return 20'sh7FFFF;
            2: return 20'($urandom_range(0, 255)) - 20'sd128;
            default: return 20'($urandom);
        endcase
    endfunction

    // extremes, every operation, empty table, zero distance, tiny weight
    task automatic test_directed();
        send_item(OP_QUERY, 20'sd0, 20'sd0);
        send_item(OP_LOAD, 20'sd0, 20'sd0);
        send_item(OP_QUERY, 20'sd0, 20'sd0);
        send_item(OP_QUERY, 20'sd1, 20'sd0);
        send_item(OP_QUERY, 20'sh7FFFF, 20'sh7FFFF);
        send_item(OP_LOAD, 20'sh80000, 20'sh80000);
        send_item(OP_QUERY, 20'sh7FFFF, 20'sh7FFFF);
        send_item(OP_NONE, 20'sh7FFFF, 20'sh80000);
        send_item(OP_QUERY, 20'sh80001, 20'sh80000);
        send_item(OP_CLEAR, 20'sd0, 20'sd0);
        send_item(OP_QUERY, 20'sd5, 20'sd5);
    endtask

    // alpha settings including the out-of-range codes
    task automatic test_alpha();
        logic [1:0] codes [4] = '{2'd2, 2'd0, 2'd3, 2'd1};
        foreach (codes[k]) begin
            write_alpha(codes[k]);
            send_item(OP_CLEAR, 20'sd0, 20'sd0);
            send_item(OP_LOAD, 20'sd0, 20'sd0);
            send_item(OP_QUERY, 20'sd1, 20'sd1);
            send_item(OP_QUERY, 20'sd16, 20'sd0);
            send_item(OP_QUERY, 20'sd3000, 20'sd0);
            send_item(OP_QUERY, 20'sh7FFFF, 20'sh7FFFF);
        end
    endtask

    // fill past capacity so loads are dropped
    task automatic test_full_table();
        send_item(OP_CLEAR, 20'sd0, 20'sd0);
        repeat (MAX_POINTS + 3) send_item(OP_LOAD, rand_coord(), rand_coord());
        send_item(OP_QUERY, rand_coord(), rand_coord());
        // hold off until everything has drained
        while (expected_words.size() != 0) @(posedge aclk);
        send_item(OP_QUERY, pt_x[MAX_POINTS-1], pt_y[MAX_POINTS-1]);
        send_item(OP_CLEAR, 20'sd0, 20'sd0);
    endtask

    // random runs: small tables loaded then queried, some noise
    task automatic test_random(int unsigned n_items);
        int unsigned n, r;
        logic signed [19:0] base_x, base_y;
        n = 0;
        while (n < n_items) begin
            if ($urandom_range(0, 7) == 0) begin
                write_alpha(2'($urandom_range(0, 3)));
                rx_stall_on = $urandom_range(0, 2) != 0;
            end
            send_item(OP_CLEAR, 20'sd0, 20'sd0);
            base_x = rand_coord();
            base_y = rand_coord();
            r = $urandom_range(0, 9);
            repeat (r) begin
                send_item(OP_LOAD, base_x + 20'($urandom_range(0, 63)),
                          base_y + 20'($urandom_range(0, 63)));
                n++;
            end
            repeat ($urandom_range(1, 6)) begin
                if ($urandom_range(0, 9) == 0)
                    send_item(op_t'($urandom_range(0, 3)), rand_coord(), rand_coord());
                else if ($urandom_range(0, 3) == 0)
                    send_item(OP_QUERY, rand_coord(), rand_coord());
                else
                    send_item(OP_QUERY, base_x + 20'($urandom_range(0, 80)),
                              base_y + 20'($urandom_range(0, 80)));
                n++;
            end
        end
    endtask

    initial begin
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_directed();
        test_alpha();
        test_full_table();
        test_random(300);
        wait_drained();
        $display("covered %0d input words (%0d queries), %0d output words checked",
                 items_sent, queries_sent, words_checked);
        $display("alpha codes 0..3, empty and full table, zero distance and saturation");
        if (mismatch_count == 0 && expected_words.size() == 0) begin
            $display("inverse_distance_weight_engine regression: pass");
        end else begin
            $display("inverse_distance_weight_engine regression: fail");
        end
        $finish;
    end
endmodule

/* inverse_distance_weight_engine.f */
rtl/idw_pkg.sv
rtl/idw_divider.sv
rtl/inverse_distance_weight_engine.sv
dv/tb_inverse_distance_weight_engine.sv
